>>> rtl/core/csra_pkg.sv
// Shared types and codes for the circular slot run allocator.
`default_nettype none
package csra_pkg;

   localparam int NUM_SLOTS_DEFAULT = 256;

   // command codes
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_BLOCK = 2'd1;
   localparam logic [1:0] CMD_ALLOC = 2'd2;

   // search mode codes; any other code searches both ways
   localparam logic [1:0] MODE_FWD = 2'd0;
   localparam logic [1:0] MODE_BWD = 2'd1;

   // result status codes
   localparam logic [1:0] STAT_PLACED  = 2'd0;
   localparam logic [1:0] STAT_NO_ROOM = 2'd1;
   localparam logic [1:0] STAT_OUTSIDE = 2'd2;
   localparam logic [1:0] STAT_DONE    = 2'd3;

   // slot map entry codes
   localparam logic [1:0] SLOT_FREE     = 2'd0;
   localparam logic [1:0] SLOT_LIGHT    = 2'd1;
   localparam logic [1:0] SLOT_OCCUPIED = 2'd2;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_BLOCK,
      ST_FWD,
      ST_BWD,
      ST_DIST,
      ST_TOL,
      ST_MARK,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

>>> rtl/core/circular_slot_run_allocator.sv
// Sequence: a clear writes every slot; a block writes each slot of the range; an allocate
// reduces the anchor modulo NUM_SLOTS, scans each searched direction slot by slot, then
// picks the nearest run, checks the tolerance, marks run_length slots and responds.
// Throughput: one item at a time; the single map read port scans one slot per cycle.
// Reset: synchronous, active high; then a clearing pass writes every slot free,
// during which req_stall stays high.
`default_nettype none
module circular_slot_run_allocator #(
   parameter int NUM_SLOTS = csra_pkg::NUM_SLOTS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_cmd,
   input  wire logic [7:0] req_range_first,
   input  wire logic [7:0] req_range_last,
   input  wire logic       req_block_as_occupied,
   input  wire logic [7:0] req_anchor_slot,
   input  wire logic [8:0] req_run_length,
   input  wire logic [1:0] req_search_mode,
   input  wire logic       req_treat_light_free,
   input  wire logic [8:0] req_max_shift,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_status,
   output logic [7:0]      rsp_found_slot,
   output logic [7:0]      rsp_shift
);

   localparam int AW  = $clog2(NUM_SLOTS);
   localparam int XW  = (AW > 9 ? AW : 9) + 1;
   localparam int DW  = AW + 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_SLOTS - 1);

   csra_pkg::state_type state_ff, state_in;

   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] prev_ff, prev_in;
   logic [AW-1:0] start_ff, start_in;
   logic [AW-1:0] fpos_ff, fpos_in;
   logic [AW-1:0] bpos_ff, bpos_in;
   logic [AW-1:0] got_ff, got_in;
   logic [8:0]    run_ff, run_in;
   logic          dv_ff, dv_in;
   logic          fok_ff, fok_in;
   logic          bok_ff, bok_in;
   logic          clr_rsp_ff, clr_rsp_in;

   logic [7:0] last_ff, last_in;
   logic       mark_ff, mark_in;
   logic [7:0] anchor_ff, anchor_in;
   logic [8:0] len_ff, len_in;
   logic [1:0] mode_ff, mode_in;
   logic       light_ff, light_in;
   logic [8:0] tol_ff, tol_in;

   logic [1:0] res_status_ff, res_status_in;
   logic [7:0] res_found_ff, res_found_in;
   logic [7:0] res_shift_ff, res_shift_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [7:0] rsp_found_ff, rsp_found_in;
   logic [7:0] rsp_shift_ff, rsp_shift_in;

   logic          map_we;
   logic [AW-1:0] map_waddr;
   logic [1:0]    map_wdata;
   logic [AW-1:0] map_raddr;
   logic          rd_open;

   logic          accept;
   logic          rsp_free;
   logic          range_ok;
   logic          anchor_big;
   logic [AW-1:0] anchor_idx;
   logic [AW-1:0] first_idx;
   logic [AW-1:0] addr_next;
   logic [AW-1:0] addr_prev;
   logic          hit;
   logic          scan_end;
   logic          mark_end;
   logic          block_end;
   logic [DW-1:0] fdist;
   logic [DW-1:0] bdist;
   logic [AW-1:0] delta;
   logic [XW-1:0] dist_ext;
   logic [XW-1:0] got_ext;
   logic [XW-1:0] anchor_ext;
   logic [XW-1:0] first_ext;
   logic          over_tol;

   csra_slot_map #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_map (
      .clock    (clock),
      .wr_en    (map_we),
      .wr_addr  (map_waddr),
      .wr_data  (map_wdata),
      .rd_addr  (map_raddr),
      .light_ok (light_ff),
      .rd_open  (rd_open)
   );

   assign req_stall = (state_ff != csra_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign range_ok   = (XW'(req_range_first) < XW'(NUM_SLOTS)) &&
                       (XW'(req_range_last) < XW'(NUM_SLOTS));
   assign anchor_big = (XW'(anchor_ff) >= XW'(NUM_SLOTS));
   assign anchor_ext = XW'(anchor_ff);
   assign anchor_idx = anchor_ext[AW-1:0];
   assign first_ext  = XW'(req_range_first);
   assign first_idx  = first_ext[AW-1:0];

   assign addr_next = (addr_ff == LAST_SLOT) ? '0 : addr_ff + AW'(1);
   assign addr_prev = (addr_ff == '0) ? LAST_SLOT : addr_ff - AW'(1);

   // run reaches the wanted length on this slot
   assign hit       = dv_ff && rd_open && ((10'(run_ff) + 10'd1) == 10'(len_ff));
   assign scan_end  = dv_ff && (hit || (cnt_ff == LAST_SLOT));
   assign mark_end  = ((XW'(cnt_ff) + XW'(1)) == XW'(len_ff));
   assign block_end = (XW'(addr_ff) == XW'(last_ff));

   assign fdist = (fpos_ff >= anchor_idx) ? DW'(fpos_ff) - DW'(anchor_idx)
                : DW'(fpos_ff) + DW'(NUM_SLOTS) - DW'(anchor_idx);
   assign bdist = (bpos_ff <= anchor_idx) ? DW'(anchor_idx) - DW'(bpos_ff)
                : DW'(anchor_idx) + DW'(NUM_SLOTS) - DW'(bpos_ff);

   assign delta    = (got_ff >= anchor_idx) ? got_ff - anchor_idx : anchor_idx - got_ff;
   assign dist_ext = XW'(delta);
   assign got_ext  = XW'(got_ff);
   assign over_tol = dist_ext > XW'(tol_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csra_pkg::ST_CLEAR: begin
            if (addr_ff == LAST_SLOT) begin
               state_in = clr_rsp_ff ? csra_pkg::ST_DONE : csra_pkg::ST_IDLE;
            end
         end
         csra_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  csra_pkg::CMD_CLEAR: state_in = csra_pkg::ST_CLEAR;
                  csra_pkg::CMD_BLOCK: state_in = range_ok ? csra_pkg::ST_BLOCK
                                                           : csra_pkg::ST_DONE;
                  csra_pkg::CMD_ALLOC: state_in = (req_run_length != '0) ? csra_pkg::ST_MOD
                                                                         : csra_pkg::ST_DONE;
                  default:             state_in = csra_pkg::ST_DONE;
               endcase
            end
         end
         csra_pkg::ST_MOD: begin
            if (!anchor_big) begin
               state_in = (mode_ff == csra_pkg::MODE_BWD) ? csra_pkg::ST_BWD
                                                          : csra_pkg::ST_FWD;
            end
         end
         csra_pkg::ST_BLOCK: begin
            if (block_end) begin
               state_in = csra_pkg::ST_DONE;
            end
         end
         csra_pkg::ST_FWD: begin
            if (scan_end) begin
               state_in = (mode_ff == csra_pkg::MODE_FWD) ? csra_pkg::ST_DIST
                                                          : csra_pkg::ST_BWD;
            end
         end
         csra_pkg::ST_BWD: begin
            if (scan_end) begin
               state_in = csra_pkg::ST_DIST;
            end
         end
         csra_pkg::ST_DIST: begin
            state_in = (fok_ff || bok_ff) ? csra_pkg::ST_TOL : csra_pkg::ST_DONE;
         end
         csra_pkg::ST_TOL: begin
            state_in = over_tol ? csra_pkg::ST_DONE : csra_pkg::ST_MARK;
         end
         csra_pkg::ST_MARK: begin
            if (mark_end) begin
               state_in = csra_pkg::ST_DONE;
            end
         end
         csra_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = csra_pkg::ST_IDLE;
            end
         end
         default: state_in = csra_pkg::ST_IDLE;
      endcase
   end

   // datapath and map control
   always_comb begin
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      prev_in       = prev_ff;
      start_in      = start_ff;
      fpos_in       = fpos_ff;
      bpos_in       = bpos_ff;
      got_in        = got_ff;
      run_in        = run_ff;
      dv_in         = dv_ff;
      fok_in        = fok_ff;
      bok_in        = bok_ff;
      clr_rsp_in    = clr_rsp_ff;
      last_in       = last_ff;
      mark_in       = mark_ff;
      anchor_in     = anchor_ff;
      len_in        = len_ff;
      mode_in       = mode_ff;
      light_in      = light_ff;
      tol_in        = tol_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_shift_in  = res_shift_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_shift_in  = rsp_shift_ff;
      map_we        = 1'b0;
      map_waddr     = addr_ff;
      map_wdata     = csra_pkg::SLOT_FREE;
      map_raddr     = addr_ff;

      case (state_ff)
         csra_pkg::ST_CLEAR: begin
            map_we  = 1'b1;
            addr_in = addr_next;
         end
         csra_pkg::ST_IDLE: begin
            if (accept) begin
               last_in       = req_range_last;
               mark_in       = req_block_as_occupied;
               anchor_in     = req_anchor_slot;
               len_in        = req_run_length;
               mode_in       = req_search_mode;
               light_in      = req_treat_light_free;
               tol_in        = req_max_shift;
               fok_in        = 1'b0;
               bok_in        = 1'b0;
               clr_rsp_in    = 1'b1;
               res_status_in = csra_pkg::STAT_DONE;
               res_found_in  = '0;
               res_shift_in  = '0;
               addr_in       = (req_cmd == csra_pkg::CMD_BLOCK) ? first_idx : '0;
               if (req_cmd == csra_pkg::CMD_ALLOC && req_run_length == '0) begin
                  res_status_in = csra_pkg::STAT_NO_ROOM;
               end
            end
         end
         csra_pkg::ST_MOD: begin
            if (anchor_big) begin
               anchor_in = anchor_ff - 8'(NUM_SLOTS);
            end else begin
               addr_in = anchor_idx;
               dv_in   = 1'b0;
               cnt_in  = '0;
               run_in  = '0;
            end
         end
         csra_pkg::ST_BLOCK: begin
            map_we    = 1'b1;
            map_wdata = mark_ff ? csra_pkg::SLOT_OCCUPIED : csra_pkg::SLOT_LIGHT;
            addr_in   = addr_next;
         end
         csra_pkg::ST_FWD, csra_pkg::ST_BWD: begin
            // issue the next read while the previous slot's data is judged
            addr_in = (state_ff == csra_pkg::ST_FWD) ? addr_next : addr_prev;
            dv_in   = 1'b1;
            prev_in = addr_ff;
            if (dv_ff) begin
               cnt_in = cnt_ff + AW'(1);
               run_in = rd_open ? run_ff + 9'd1 : '0;
               if (rd_open && run_ff == '0) begin
                  start_in = prev_ff;
               end
               if (hit) begin
                  if (state_ff == csra_pkg::ST_FWD) begin
                     fok_in  = 1'b1;
                     fpos_in = (run_ff == '0) ? prev_ff : start_ff;
                  end else begin
                     bok_in  = 1'b1;
                     bpos_in = prev_ff;
                  end
               end
            end
            // restart from the anchor for the backward pass
            if (state_ff == csra_pkg::ST_FWD && scan_end && mode_ff != csra_pkg::MODE_FWD) begin
               addr_in = anchor_idx;
               dv_in   = 1'b0;
               cnt_in  = '0;
               run_in  = '0;
            end
         end
         csra_pkg::ST_DIST: begin
            if (fok_ff && bok_ff) begin
               got_in = (bdist < fdist) ? bpos_ff : fpos_ff;
            end else if (fok_ff) begin
               got_in = fpos_ff;
            end else begin
               got_in = bpos_ff;
            end
            if (!fok_ff && !bok_ff) begin
               res_status_in = csra_pkg::STAT_NO_ROOM;
            end
         end
         csra_pkg::ST_TOL: begin
            res_shift_in = (dist_ext > XW'(255)) ? 8'hFF : dist_ext[7:0];
            if (over_tol) begin
               res_status_in = csra_pkg::STAT_OUTSIDE;
            end else begin
               res_status_in = csra_pkg::STAT_PLACED;
               res_found_in  = got_ext[7:0];
               addr_in       = got_ff;
               cnt_in        = '0;
            end
         end
         csra_pkg::ST_MARK: begin
            map_we    = 1'b1;
            map_wdata = csra_pkg::SLOT_OCCUPIED;
            addr_in   = addr_next;
            cnt_in    = cnt_ff + AW'(1);
         end
         csra_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_shift_in  = res_shift_ff;
            end
         end
         default: begin
            addr_in = addr_ff;
         end
      endcase
   end

   assign rsp_valid_in = (state_ff == csra_pkg::ST_DONE && rsp_free) ||
                         (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csra_pkg::ST_CLEAR;
         addr_ff      <= '0;
         dv_ff        <= 1'b0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         dv_ff        <= dv_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      prev_ff       <= prev_in;
      start_ff      <= start_in;
      fpos_ff       <= fpos_in;
      bpos_ff       <= bpos_in;
      got_ff        <= got_in;
      run_ff        <= run_in;
      fok_ff        <= fok_in;
      bok_ff        <= bok_in;
      last_ff       <= last_in;
      mark_ff       <= mark_in;
      anchor_ff     <= anchor_in;
      len_ff        <= len_in;
      mode_ff       <= mode_in;
      light_ff      <= light_in;
      tol_ff        <= tol_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_shift_ff  <= res_shift_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_shift_ff  <= rsp_shift_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_found_slot = rsp_found_ff;
   assign rsp_shift      = rsp_shift_ff;

   // a run being tracked never reaches the wanted length without ending the scan
   a_run_below_len: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == csra_pkg::ST_FWD || state_ff == csra_pkg::ST_BWD) && dv_ff)
      |-> (run_ff < len_ff))
      else $error("run counter reached run length during scan");

   // a placed run always lies within the shift tolerance
   a_placed_in_tol: assert property (@(posedge clock) disable iff (reset)
      (state_ff == csra_pkg::ST_DONE && res_status_ff == csra_pkg::STAT_PLACED)
      |-> (XW'(res_shift_ff) <= XW'(tol_ff)))
      else $error("placed run outside tolerance");

   // found slot is zero for every result but a placement
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != csra_pkg::STAT_PLACED) |-> (rsp_found_ff == '0))
      else $error("found slot set on a non-placed result");

   // map writes happen only in clear, block and mark states
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      map_we |-> (state_ff == csra_pkg::ST_CLEAR || state_ff == csra_pkg::ST_BLOCK ||
                  state_ff == csra_pkg::ST_MARK))
      else $error("slot map written outside a write state");

   // a marking pass follows only a tolerance check that passed
   a_mark_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == csra_pkg::ST_MARK) |-> (res_status_ff == csra_pkg::STAT_PLACED))
      else $error("marking started without a placement");

endmodule
`default_nettype wire

>>> rtl/core/csra_slot_map.sv
// Slot map memory with registered read and open-slot decode.
`default_nettype none
module csra_slot_map #(
   parameter int NUM_SLOTS = csra_pkg::NUM_SLOTS_DEFAULT,
   localparam int AW = $clog2(NUM_SLOTS)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [1:0]    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   input  wire logic          light_ok,
   output logic               rd_open
);

   logic [1:0] mem [NUM_SLOTS];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_open = (rd_data_ff == csra_pkg::SLOT_FREE) ||
                    (light_ok && (rd_data_ff == csra_pkg::SLOT_LIGHT));

endmodule
`default_nettype wire
